### rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// shared constants, tables and the cell word type for the polar/cartesian converter
// used by pcc_pre, pcc_cell, pcc_post and polar_cartesian_convert; no dependencies

package pcc_pkg;

    localparam int ROTATION_STAGES = 18;
    localparam int DISTANCE_BITS   = 18;

    localparam int N_STAGES = (ROTATION_STAGES < 24) ? ROTATION_STAGES : 24;
    localparam int STAGE_W  = $clog2(N_STAGES);

    // field widths
    localparam int RANGE_W = 18;
    localparam int ANGLE_W = 15;
    localparam int COORD_W = 19;
    localparam int INTEN_W = 16;

    // angle units: 1/64 degree in, 2^32 binary units per turn inside
    localparam int TURN_Q    = 23040;
    localparam int QUARTER_Q = TURN_Q / 4;
    localparam int HALF_Q    = TURN_Q / 2;
    localparam int ZB        = 32;
    localparam int Z_W       = ZB + 1;
    localparam int ANG_DIV   = 45;
    localparam int ANG_SHIFT = ZB - 9;

    localparam logic [ANGLE_W-1:0] ANG_TURN     = ANGLE_W'(TURN_Q);
    localparam logic [ANGLE_W-1:0] ANG_QUARTER  = ANGLE_W'(QUARTER_Q);
    localparam logic [ANGLE_W-1:0] ANG_HALF     = ANGLE_W'(HALF_Q);
    localparam logic [ANGLE_W-1:0] ANG_3QUARTER = ANGLE_W'(3 * QUARTER_Q);

    localparam int MAG_W      = $clog2(QUARTER_Q + 1);
    localparam int QUO_W      = $clog2(QUARTER_Q / ANG_DIV + 1);
    localparam int REM_W      = $clog2(ANG_DIV);
    localparam int ZM_W       = QUO_W + ANG_SHIFT;
    localparam int DIV_SHIFT  = 20;
    localparam int DIV_MUL    = ((1 << DIV_SHIFT) + ANG_DIV - 1) / ANG_DIV;
    localparam int DIV_MUL_W  = $clog2(DIV_MUL + 1);
    localparam int DIV_PROD_W = MAG_W + DIV_MUL_W;

    localparam logic [DIV_MUL_W-1:0] DIV_MUL_C = DIV_MUL_W'(DIV_MUL);
    localparam logic [MAG_W-1:0]     ANG_DIV_C = MAG_W'(ANG_DIV);
    localparam logic signed [Z_W-1:0] Z_HALF   = Z_W'(longint'(1) << (ZB - 1));

    // datapath widths
    localparam int FRAC       = 8;
    localparam int CORE_W     = COORD_W + FRAC + 3;
    localparam int GAIN_SPLIT = 15;
    localparam int PROD_W     = CORE_W + GAIN_SPLIT;
    localparam int SUM_W      = PROD_W + 1;
    localparam int RND_SHIFT  = FRAC + GAIN_SPLIT;
    localparam int UNS_W      = SUM_W - RND_SHIFT;
    localparam int SUNS_W     = UNS_W + 1;
    localparam int CMP_W      = ((DISTANCE_BITS + 2 > SUNS_W) ? DISTANCE_BITS + 2 : SUNS_W) + 1;
    localparam int ZP_W       = ZB + ANGLE_W;

    localparam logic signed [CMP_W-1:0] COORD_MAX_C =
        CMP_W'((longint'(1) << DISTANCE_BITS) - 1);
    localparam logic signed [CMP_W-1:0] COORD_MIN_C =
        CMP_W'(-(longint'(1) << DISTANCE_BITS));
    localparam logic [CMP_W-1:0] RANGE_MAX_C =
        CMP_W'((longint'(1) << DISTANCE_BITS) - 1);

    // arctangent of 2^-i in binary angle units
    typedef logic [ZB-1:0] t_atan_full [24];
    typedef logic [ZB-1:0] t_atan_tab [N_STAGES];

    localparam t_atan_full ATAN_FULL = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
    };

    function automatic t_atan_tab f_atan_tab();
        t_atan_tab tab;
        for (int i = 0; i < N_STAGES; i++) begin
            tab[i] = ATAN_FULL[i];
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = f_atan_tab();

    // fraction part of the degree to binary angle scaling, one entry per remainder mod 45
    typedef logic [ANG_SHIFT-1:0] t_frac_tab [ANG_DIV];

    function automatic t_frac_tab f_frac_tab();
        t_frac_tab tab;
        for (int b = 0; b < ANG_DIV; b++) begin
            tab[b] = ANG_SHIFT'(((longint'(b) << ANG_SHIFT) + (ANG_DIV / 2)) / ANG_DIV);
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = f_frac_tab();

    // cordic gain: K^2 in Q60, then 1/K in Q30
    function automatic longint unsigned f_gain_sq();
        longint unsigned p;
        p = longint'(1) << 60;
        for (int i = 0; i < N_STAGES; i++) begin
            p = p + (p >> (2 * i));
        end
        return p;
    endfunction

    function automatic longint unsigned f_isqrt(input longint unsigned v);
        longint unsigned rem_v;
        longint unsigned res;
        longint unsigned bit_v;
        rem_v = v;
        res   = 0;
        bit_v = longint'(1) << 62;
        for (int k = 0; k < 32; k++) begin
            if (bit_v > v) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bit_v != 0) begin
                if (rem_v >= res + bit_v) begin
                    rem_v = rem_v - (res + bit_v);
                    res   = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    localparam longint unsigned GAIN_ROOT = f_isqrt(f_gain_sq());
    localparam longint unsigned INV_GAIN  = (longint'(1) << 60) / GAIN_ROOT;
    localparam logic [GAIN_SPLIT-1:0] GAIN_HI = GAIN_SPLIT'(INV_GAIN >> GAIN_SPLIT);
    localparam logic [GAIN_SPLIT-1:0] GAIN_LO = GAIN_SPLIT'(INV_GAIN);

    // word handed from cell to cell
    typedef struct packed {
        logic                      kind;
        logic                      neg;
        logic                      origin;
        logic signed [CORE_W-1:0]  x;
        logic signed [CORE_W-1:0]  y;
        logic signed [Z_W-1:0]     z;
        logic [INTEN_W-1:0]        intensity;
    } t_cell;

endpackage

### rtl/pcc_pre.sv
`timescale 1ns / 1ps
// input conditioning: angle folding and scaling to binary angle, half plane fold for xy
// three register stages; depends on pcc_pkg

module pcc_pre (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 i_command,
    input  logic [pcc_pkg::RANGE_W-1:0]          i_range_q,
    input  logic [pcc_pkg::ANGLE_W-1:0]          i_angle_q,
    input  logic signed [pcc_pkg::COORD_W-1:0]   i_x_in_q,
    input  logic signed [pcc_pkg::COORD_W-1:0]   i_y_in_q,
    input  logic [pcc_pkg::INTEN_W-1:0]          i_intensity,
    output logic                                 o_valid,
    output pcc_pkg::t_cell                       o_cell
);

    // stage 1
    logic [pcc_pkg::ANGLE_W-1:0]        w_angle;
    logic [pcc_pkg::ANGLE_W-1:0]        w_diff;
    logic [pcc_pkg::RANGE_W-1:0]        n_s1_range;
    logic [pcc_pkg::MAG_W-1:0]          n_s1_mag;
    logic                               n_s1_tneg;
    logic                               n_s1_neg;
    logic signed [pcc_pkg::COORD_W:0]   w_xe;
    logic signed [pcc_pkg::COORD_W:0]   w_ye;
    logic signed [pcc_pkg::COORD_W:0]   n_s1_cx;
    logic signed [pcc_pkg::COORD_W:0]   n_s1_cy;

    logic                               r_s1_valid;
    logic                               r_s1_kind;
    logic [pcc_pkg::RANGE_W-1:0]        r_s1_range;
    logic [pcc_pkg::MAG_W-1:0]          r_s1_mag;
    logic                               r_s1_tneg;
    logic                               r_s1_neg;
    logic signed [pcc_pkg::COORD_W:0]   r_s1_cx;
    logic signed [pcc_pkg::COORD_W:0]   r_s1_cy;
    logic                               r_s1_zflip;
    logic                               r_s1_origin;
    logic [pcc_pkg::INTEN_W-1:0]        r_s1_inten;

    // stage 2
    logic [pcc_pkg::DIV_PROD_W-1:0]     w_quo_prod;
    logic                               r_s2_valid;
    logic                               r_s2_kind;
    logic [pcc_pkg::RANGE_W-1:0]        r_s2_range;
    logic [pcc_pkg::MAG_W-1:0]          r_s2_mag;
    logic [pcc_pkg::QUO_W-1:0]          r_s2_quo;
    logic                               r_s2_tneg;
    logic                               r_s2_neg;
    logic signed [pcc_pkg::COORD_W:0]   r_s2_cx;
    logic signed [pcc_pkg::COORD_W:0]   r_s2_cy;
    logic                               r_s2_zflip;
    logic                               r_s2_origin;
    logic [pcc_pkg::INTEN_W-1:0]        r_s2_inten;

    // stage 3
    logic [pcc_pkg::MAG_W-1:0]          w_q45;
    logic [pcc_pkg::MAG_W-1:0]          w_rem_full;
    logic [pcc_pkg::REM_W-1:0]          w_rem;
    logic [pcc_pkg::ZM_W-1:0]           w_zmag;
    logic signed [pcc_pkg::Z_W-1:0]     w_zpos;
    pcc_pkg::t_cell                     n_cell;
    pcc_pkg::t_cell                     r_cell;
    logic                               r_valid;

    always_comb begin
        if ({{(pcc_pkg::CMP_W-pcc_pkg::RANGE_W){1'b0}}, i_range_q} > pcc_pkg::RANGE_MAX_C) begin
            n_s1_range = pcc_pkg::RANGE_MAX_C[pcc_pkg::RANGE_W-1:0];
        end else begin
            n_s1_range = i_range_q;
        end

        w_angle = (i_angle_q >= pcc_pkg::ANG_TURN) ? i_angle_q - pcc_pkg::ANG_TURN : i_angle_q;

        // fold into [-90, 90] degrees; the middle half turn flips the result sign
        priority if (w_angle <= pcc_pkg::ANG_QUARTER) begin
            w_diff    = w_angle;
            n_s1_tneg = 1'b0;
            n_s1_neg  = 1'b0;
        end else if (w_angle <= pcc_pkg::ANG_3QUARTER) begin
            n_s1_neg = 1'b1;
            if (w_angle < pcc_pkg::ANG_HALF) begin
                w_diff    = pcc_pkg::ANG_HALF - w_angle;
                n_s1_tneg = 1'b1;
            end else begin
                w_diff    = w_angle - pcc_pkg::ANG_HALF;
                n_s1_tneg = 1'b0;
            end
        end else begin
            w_diff    = pcc_pkg::ANG_TURN - w_angle;
            n_s1_tneg = 1'b1;
            n_s1_neg  = 1'b0;
        end
        n_s1_mag = w_diff[pcc_pkg::MAG_W-1:0];

        // left half plane: rotate by half a turn first
        w_xe = $signed({i_x_in_q[pcc_pkg::COORD_W-1], i_x_in_q});
        w_ye = $signed({i_y_in_q[pcc_pkg::COORD_W-1], i_y_in_q});
        if (i_x_in_q[pcc_pkg::COORD_W-1]) begin
            n_s1_cx = -w_xe;
            n_s1_cy = -w_ye;
        end else begin
            n_s1_cx = w_xe;
            n_s1_cy = w_ye;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind   <= i_command;
        r_s1_range  <= n_s1_range;
        r_s1_mag    <= n_s1_mag;
        r_s1_tneg   <= n_s1_tneg;
        r_s1_neg    <= n_s1_neg;
        r_s1_cx     <= n_s1_cx;
        r_s1_cy     <= n_s1_cy;
        r_s1_zflip  <= i_x_in_q[pcc_pkg::COORD_W-1];
        r_s1_origin <= (i_x_in_q == '0) && (i_y_in_q == '0);
        r_s1_inten  <= i_intensity;
    end

    // quotient by 45 through a reciprocal multiply, exact over the folded range
    assign w_quo_prod = {{pcc_pkg::DIV_MUL_W{1'b0}}, r_s1_mag}
                      * {{pcc_pkg::MAG_W{1'b0}}, pcc_pkg::DIV_MUL_C};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_kind   <= r_s1_kind;
        r_s2_range  <= r_s1_range;
        r_s2_mag    <= r_s1_mag;
        r_s2_quo    <= w_quo_prod[pcc_pkg::DIV_SHIFT +: pcc_pkg::QUO_W];
        r_s2_tneg   <= r_s1_tneg;
        r_s2_neg    <= r_s1_neg;
        r_s2_cx     <= r_s1_cx;
        r_s2_cy     <= r_s1_cy;
        r_s2_zflip  <= r_s1_zflip;
        r_s2_origin <= r_s1_origin;
        r_s2_inten  <= r_s1_inten;
    end

    always_comb begin
        w_q45      = {{(pcc_pkg::MAG_W-pcc_pkg::QUO_W){1'b0}}, r_s2_quo} * pcc_pkg::ANG_DIV_C;
        w_rem_full = r_s2_mag - w_q45;
        w_rem      = w_rem_full[pcc_pkg::REM_W-1:0];
        w_zmag     = {r_s2_quo, {pcc_pkg::ANG_SHIFT{1'b0}}}
                   + {{pcc_pkg::QUO_W{1'b0}}, pcc_pkg::FRAC_TAB[w_rem]};
        w_zpos     = $signed({{(pcc_pkg::Z_W-pcc_pkg::ZM_W){1'b0}}, w_zmag});

        n_cell           = r_cell;
        n_cell.kind      = r_s2_kind;
        n_cell.intensity = r_s2_inten;
        if (!r_s2_kind) begin
            n_cell.neg    = r_s2_neg;
            n_cell.origin = 1'b0;
            n_cell.x      = $signed({{(pcc_pkg::CORE_W-pcc_pkg::RANGE_W-pcc_pkg::FRAC){1'b0}},
                                     r_s2_range, {pcc_pkg::FRAC{1'b0}}});
            n_cell.y      = '0;
            n_cell.z      = r_s2_tneg ? -w_zpos : w_zpos;
        end else begin
            n_cell.neg    = 1'b0;
            n_cell.origin = r_s2_origin;
            n_cell.x      = $signed({{(pcc_pkg::CORE_W-pcc_pkg::COORD_W-1-pcc_pkg::FRAC)
                                      {r_s2_cx[pcc_pkg::COORD_W]}},
                                     r_s2_cx, {pcc_pkg::FRAC{1'b0}}});
            n_cell.y      = $signed({{(pcc_pkg::CORE_W-pcc_pkg::COORD_W-1-pcc_pkg::FRAC)
                                      {r_s2_cy[pcc_pkg::COORD_W]}},
                                     r_s2_cy, {pcc_pkg::FRAC{1'b0}}});
            n_cell.z      = r_s2_zflip ? pcc_pkg::Z_HALF : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

### rtl/pcc_cell.sv
`timescale 1ns / 1ps
// one cordic micro-rotation, registered; rotation mode for polar words, vectoring for xy words
// depends on pcc_pkg

module pcc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pcc_pkg::STAGE_W-1:0]   i_stage,
    input  logic                          i_valid,
    input  pcc_pkg::t_cell                i_cell,
    output logic                          o_valid,
    output pcc_pkg::t_cell                o_cell
);

    logic signed [pcc_pkg::CORE_W-1:0]  w_x;
    logic signed [pcc_pkg::CORE_W-1:0]  w_y;
    logic signed [pcc_pkg::CORE_W-1:0]  w_dx;
    logic signed [pcc_pkg::CORE_W-1:0]  w_dy;
    logic signed [pcc_pkg::Z_W-1:0]     w_z;
    logic signed [pcc_pkg::Z_W-1:0]     w_atan;
    logic                               w_dir;
    pcc_pkg::t_cell                     n_cell;
    pcc_pkg::t_cell                     r_cell;
    logic                               r_valid;

    assign w_x    = i_cell.x;
    assign w_y    = i_cell.y;
    assign w_z    = i_cell.z;
    assign w_dx   = w_y >>> i_stage;
    assign w_dy   = w_x >>> i_stage;
    assign w_atan = $signed({1'b0, pcc_pkg::ATAN_TAB[i_stage]});

    // rotate toward z = 0 for polar words, toward y = 0 for xy words
    assign w_dir = i_cell.kind ? w_y[pcc_pkg::CORE_W-1] : ~w_z[pcc_pkg::Z_W-1];

    always_comb begin
        n_cell = i_cell;
        if (w_dir) begin
            n_cell.x = w_x - w_dx;
            n_cell.y = w_y + w_dy;
            n_cell.z = w_z - w_atan;
        end else begin
            n_cell.x = w_x + w_dx;
            n_cell.y = w_y - w_dy;
            n_cell.z = w_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

### rtl/pcc_post.sv
`timescale 1ns / 1ps
// gain removal with rounding, binary angle to 1/64 degree, saturation and result register
// three register stages; depends on pcc_pkg

module pcc_post (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  pcc_pkg::t_cell                       i_cell,
    output logic                                 o_valid,
    output logic                                 o_kind,
    output logic signed [pcc_pkg::COORD_W-1:0]   o_x_out_q,
    output logic signed [pcc_pkg::COORD_W-1:0]   o_y_out_q,
    output logic [pcc_pkg::RANGE_W-1:0]          o_range_out_q,
    output logic [pcc_pkg::ANGLE_W-1:0]          o_angle_out_q,
    output logic [pcc_pkg::INTEN_W-1:0]          o_intensity_out
);

    localparam logic [pcc_pkg::SUM_W-1:0]  RND_HALF =
        pcc_pkg::SUM_W'(1) << (pcc_pkg::RND_SHIFT - 1);
    localparam logic [pcc_pkg::ZP_W:0]     ZRND     = (pcc_pkg::ZP_W + 1)'(1) << (pcc_pkg::ZB - 1);

    // stage 1
    logic [pcc_pkg::CORE_W-1:0]    w_mx;
    logic [pcc_pkg::CORE_W-1:0]    w_my;
    logic                          r_p1_valid;
    logic                          r_p1_kind;
    logic                          r_p1_origin;
    logic                          r_p1_sx;
    logic                          r_p1_sy;
    logic [pcc_pkg::PROD_W-1:0]    r_px_hi;
    logic [pcc_pkg::PROD_W-1:0]    r_px_lo;
    logic [pcc_pkg::PROD_W-1:0]    r_py_hi;
    logic [pcc_pkg::PROD_W-1:0]    r_py_lo;
    logic [pcc_pkg::ZP_W-1:0]      r_zp;
    logic [pcc_pkg::INTEN_W-1:0]   r_p1_inten;

    // stage 2
    logic [pcc_pkg::SUM_W-1:0]     w_tx;
    logic [pcc_pkg::SUM_W-1:0]     w_ty;
    logic [pcc_pkg::SUM_W-1:0]     w_rx;
    logic [pcc_pkg::SUM_W-1:0]     w_ry;
    logic [pcc_pkg::UNS_W-1:0]     w_ux;
    logic [pcc_pkg::UNS_W-1:0]     w_uy;
    logic [pcc_pkg::ZP_W:0]        w_za;
    logic [pcc_pkg::ANGLE_W:0]     w_a;
    logic                          r_p2_valid;
    logic                          r_p2_kind;
    logic                          r_p2_origin;
    logic signed [pcc_pkg::SUNS_W-1:0] r_vx;
    logic signed [pcc_pkg::SUNS_W-1:0] r_vy;
    logic [pcc_pkg::UNS_W-1:0]     r_ux;
    logic [pcc_pkg::ANGLE_W-1:0]   r_ang;
    logic [pcc_pkg::INTEN_W-1:0]   r_p2_inten;

    // stage 3
    logic signed [pcc_pkg::CMP_W-1:0] w_ex;
    logic signed [pcc_pkg::CMP_W-1:0] w_ey;
    logic signed [pcc_pkg::CMP_W-1:0] w_cx;
    logic signed [pcc_pkg::CMP_W-1:0] w_cy;
    logic [pcc_pkg::CMP_W-1:0]     w_er;
    logic [pcc_pkg::CMP_W-1:0]     w_cr;
    logic signed [pcc_pkg::COORD_W-1:0] n_x;
    logic signed [pcc_pkg::COORD_W-1:0] n_y;
    logic [pcc_pkg::RANGE_W-1:0]   n_range;
    logic [pcc_pkg::ANGLE_W-1:0]   n_angle;
    logic                          r_valid;
    logic                          r_kind;
    logic signed [pcc_pkg::COORD_W-1:0] r_x;
    logic signed [pcc_pkg::COORD_W-1:0] r_y;
    logic [pcc_pkg::RANGE_W-1:0]   r_range;
    logic [pcc_pkg::ANGLE_W-1:0]   r_angle;
    logic [pcc_pkg::INTEN_W-1:0]   r_inten;

    assign w_mx = $unsigned(i_cell.x[pcc_pkg::CORE_W-1] ? -i_cell.x : i_cell.x);
    assign w_my = $unsigned(i_cell.y[pcc_pkg::CORE_W-1] ? -i_cell.y : i_cell.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_valid;
        end
    end

    // 1/K split in two halves so each product stays narrow
    always_ff @(posedge i_clk) begin
        r_p1_kind   <= i_cell.kind;
        r_p1_origin <= i_cell.origin;
        r_p1_sx     <= i_cell.x[pcc_pkg::CORE_W-1] ^ i_cell.neg;
        r_p1_sy     <= i_cell.y[pcc_pkg::CORE_W-1] ^ i_cell.neg;
        r_px_hi     <= {{pcc_pkg::GAIN_SPLIT{1'b0}}, w_mx}
                     * {{pcc_pkg::CORE_W{1'b0}}, pcc_pkg::GAIN_HI};
        r_px_lo     <= {{pcc_pkg::GAIN_SPLIT{1'b0}}, w_mx}
                     * {{pcc_pkg::CORE_W{1'b0}}, pcc_pkg::GAIN_LO};
        r_py_hi     <= {{pcc_pkg::GAIN_SPLIT{1'b0}}, w_my}
                     * {{pcc_pkg::CORE_W{1'b0}}, pcc_pkg::GAIN_HI};
        r_py_lo     <= {{pcc_pkg::GAIN_SPLIT{1'b0}}, w_my}
                     * {{pcc_pkg::CORE_W{1'b0}}, pcc_pkg::GAIN_LO};
        r_zp        <= {{pcc_pkg::ANGLE_W{1'b0}}, i_cell.z[pcc_pkg::ZB-1:0]}
                     * {{pcc_pkg::ZB{1'b0}}, pcc_pkg::ANG_TURN};
        r_p1_inten  <= i_cell.intensity;
    end

    // round half away from zero on magnitudes
    always_comb begin
        w_tx = {1'b0, r_px_hi}
             + {{(pcc_pkg::GAIN_SPLIT+1){1'b0}}, r_px_lo[pcc_pkg::PROD_W-1:pcc_pkg::GAIN_SPLIT]};
        w_ty = {1'b0, r_py_hi}
             + {{(pcc_pkg::GAIN_SPLIT+1){1'b0}}, r_py_lo[pcc_pkg::PROD_W-1:pcc_pkg::GAIN_SPLIT]};
        w_rx = w_tx + RND_HALF;
        w_ry = w_ty + RND_HALF;
        w_ux = w_rx[pcc_pkg::RND_SHIFT +: pcc_pkg::UNS_W];
        w_uy = w_ry[pcc_pkg::RND_SHIFT +: pcc_pkg::UNS_W];
        w_za = {1'b0, r_zp} + ZRND;
        w_a  = w_za[pcc_pkg::ZB +: pcc_pkg::ANGLE_W + 1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_kind   <= r_p1_kind;
        r_p2_origin <= r_p1_origin;
        r_vx        <= r_p1_sx ? -$signed({1'b0, w_ux}) : $signed({1'b0, w_ux});
        r_vy        <= r_p1_sy ? -$signed({1'b0, w_uy}) : $signed({1'b0, w_uy});
        r_ux        <= w_ux;
        // a full turn after rounding wraps to zero
        r_ang       <= (w_a >= {1'b0, pcc_pkg::ANG_TURN}) ? '0 : w_a[pcc_pkg::ANGLE_W-1:0];
        r_p2_inten  <= r_p1_inten;
    end

    always_comb begin
        w_ex = $signed({{(pcc_pkg::CMP_W-pcc_pkg::SUNS_W){r_vx[pcc_pkg::SUNS_W-1]}}, r_vx});
        w_ey = $signed({{(pcc_pkg::CMP_W-pcc_pkg::SUNS_W){r_vy[pcc_pkg::SUNS_W-1]}}, r_vy});
        w_er = {{(pcc_pkg::CMP_W-pcc_pkg::UNS_W){1'b0}}, r_ux};

        priority if (w_ex < pcc_pkg::COORD_MIN_C) begin
            w_cx = pcc_pkg::COORD_MIN_C;
        end else if (w_ex > pcc_pkg::COORD_MAX_C) begin
            w_cx = pcc_pkg::COORD_MAX_C;
        end else begin
            w_cx = w_ex;
        end

        priority if (w_ey < pcc_pkg::COORD_MIN_C) begin
            w_cy = pcc_pkg::COORD_MIN_C;
        end else if (w_ey > pcc_pkg::COORD_MAX_C) begin
            w_cy = pcc_pkg::COORD_MAX_C;
        end else begin
            w_cy = w_ey;
        end

        w_cr = (w_er > pcc_pkg::RANGE_MAX_C) ? pcc_pkg::RANGE_MAX_C : w_er;

        if (!r_p2_kind) begin
            n_x     = w_cx[pcc_pkg::COORD_W-1:0];
            n_y     = w_cy[pcc_pkg::COORD_W-1:0];
            n_range = '0;
            n_angle = '0;
        end else if (r_p2_origin) begin
            n_x     = '0;
            n_y     = '0;
            n_range = '0;
            n_angle = '0;
        end else begin
            n_x     = '0;
            n_y     = '0;
            n_range = w_cr[pcc_pkg::RANGE_W-1:0];
            n_angle = r_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= r_p2_kind;
        r_x     <= n_x;
        r_y     <= n_y;
        r_range <= n_range;
        r_angle <= n_angle;
        r_inten <= r_p2_inten;
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_x_out_q       = r_x;
    assign o_y_out_q       = r_y;
    assign o_range_out_q   = r_range;
    assign o_angle_out_q   = r_angle;
    assign o_intensity_out = r_inten;

endmodule

### rtl/polar_cartesian_convert.sv
`timescale 1ns / 1ps
// polar <-> cartesian point converter, top level
// depends on pcc_pkg, pcc_pre, pcc_cell, pcc_post
//
// usage:
//   a word is taken at each rising edge with start high and busy low; busy is
//   always low, so a new point can be given every cycle.
//   i_command 0 turns (i_range_q, i_angle_q) into (o_x_out_q, o_y_out_q);
//   i_command 1 turns (i_x_in_q, i_y_in_q) into (o_range_out_q, o_angle_out_q).
//   fields not used by a result kind read as zero; intensity is passed along.
//   every word gives one result, shown for one cycle with o_valid high.
//   each word passes through three input conditioning stages, one cordic cell
//   per rotation stage and three output stages for gain removal, rounding and
//   saturation.
//   throughput is one point per clock, set by the cell chain, where each cell
//   does one micro-rotation per cycle and hands its word on.
//   results come out in input order; the receiver must take each one as it
//   appears, there is no hold-off.
//   synchronous reset empties the pipeline: no result appears for words taken
//   before or during reset.

module polar_cartesian_convert (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_command,
    input  logic [pcc_pkg::RANGE_W-1:0]          i_range_q,
    input  logic [pcc_pkg::ANGLE_W-1:0]          i_angle_q,
    input  logic signed [pcc_pkg::COORD_W-1:0]   i_x_in_q,
    input  logic signed [pcc_pkg::COORD_W-1:0]   i_y_in_q,
    input  logic [pcc_pkg::INTEN_W-1:0]          i_intensity,
    output logic                                 o_valid,
    output logic                                 o_kind,
    output logic signed [pcc_pkg::COORD_W-1:0]   o_x_out_q,
    output logic signed [pcc_pkg::COORD_W-1:0]   o_y_out_q,
    output logic [pcc_pkg::RANGE_W-1:0]          o_range_out_q,
    output logic [pcc_pkg::ANGLE_W-1:0]          o_angle_out_q,
    output logic [pcc_pkg::INTEN_W-1:0]          o_intensity_out
);

    logic           w_accept;
    logic           w_valid [pcc_pkg::N_STAGES+1];
    pcc_pkg::t_cell w_cell  [pcc_pkg::N_STAGES+1];

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    pcc_pre u_pre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_command   (i_command),
        .i_range_q   (i_range_q),
        .i_angle_q   (i_angle_q),
        .i_x_in_q    (i_x_in_q),
        .i_y_in_q    (i_y_in_q),
        .i_intensity (i_intensity),
        .o_valid     (w_valid[0]),
        .o_cell      (w_cell[0])
    );

    for (genvar g = 0; g < pcc_pkg::N_STAGES; g++) begin : g_cell
        pcc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (pcc_pkg::STAGE_W'(g)),
            .i_valid (w_valid[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    pcc_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid[pcc_pkg::N_STAGES]),
        .i_cell          (w_cell[pcc_pkg::N_STAGES]),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_x_out_q       (o_x_out_q),
        .o_y_out_q       (o_y_out_q),
        .o_range_out_q   (o_range_out_q),
        .o_angle_out_q   (o_angle_out_q),
        .o_intensity_out (o_intensity_out)
    );

    // polar results carry no xy
    a_polar_no_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_x_out_q == '0) && (o_y_out_q == '0))
        else $error("polar result with nonzero xy");

    // xy results carry no range or angle
    a_xy_no_polar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> (o_range_out_q == '0) && (o_angle_out_q == '0))
        else $error("xy result with nonzero range or angle");

    // output angle is wrapped into one turn
    a_angle_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_angle_out_q < pcc_pkg::ANG_TURN))
        else $error("angle outside one turn");

    // a word leaving the last cell reaches the output through the registered stages of pcc_post
    a_tail_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[pcc_pkg::N_STAGES] |-> ##3 o_valid)
        else $error("word lost between cell chain and output");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for polar_cartesian_convert: directed table then random words
// depends on pcc_pkg and the polar_cartesian_convert rtl; holds its own cordic predictor

module testbench;

    localparam logic CMD_TO_XY    = 1'b0;
    localparam logic CMD_TO_POLAR = 1'b1;
    localparam int   N_ROWS       = 25;
    localparam int   WORDS_PER_PHASE = 110;
    localparam longint DIST_MAX   = (longint'(1) << pcc_pkg::DISTANCE_BITS) - 1;
    localparam longint DIST_MIN   = -(longint'(1) << pcc_pkg::DISTANCE_BITS);

    typedef struct packed {
        logic                               cmd;
        logic [pcc_pkg::RANGE_W-1:0]        rng;
        logic [pcc_pkg::ANGLE_W-1:0]        ang;
        logic signed [pcc_pkg::COORD_W-1:0] xin;
        logic signed [pcc_pkg::COORD_W-1:0] yin;
        logic [pcc_pkg::INTEN_W-1:0]        inten;
    } t_word;

    typedef struct packed {
        logic                               kind;
        logic signed [pcc_pkg::COORD_W-1:0] x_out;
        logic signed [pcc_pkg::COORD_W-1:0] y_out;
        logic [pcc_pkg::RANGE_W-1:0]        range_out;
        logic [pcc_pkg::ANGLE_W-1:0]        angle_out;
        logic [pcc_pkg::INTEN_W-1:0]        intensity_out;
    } t_point;

    typedef struct packed {
        t_word  w;
        logic   pinned;
        t_point want;
    } t_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic                               i_command;
    logic [pcc_pkg::RANGE_W-1:0]        i_range_q;
    logic [pcc_pkg::ANGLE_W-1:0]        i_angle_q;
    logic signed [pcc_pkg::COORD_W-1:0] i_x_in_q;
    logic signed [pcc_pkg::COORD_W-1:0] i_y_in_q;
    logic [pcc_pkg::INTEN_W-1:0]        i_intensity;
    logic                               o_valid;
    logic                               o_kind;
    logic signed [pcc_pkg::COORD_W-1:0] o_x_out_q;
    logic signed [pcc_pkg::COORD_W-1:0] o_y_out_q;
    logic [pcc_pkg::RANGE_W-1:0]        o_range_out_q;
    logic [pcc_pkg::ANGLE_W-1:0]        o_angle_out_q;
    logic [pcc_pkg::INTEN_W-1:0]        o_intensity_out;

    // typed-in expectation travels with the word it belongs to
    logic   pin_on;
    t_point pin_val;

    t_point          pending_points[$];
    int              mismatch_count;
    longint unsigned inv_gain_q30;
    t_row            dir_rows [N_ROWS];

    polar_cartesian_convert u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_range_q       (i_range_q),
        .i_angle_q       (i_angle_q),
        .i_x_in_q        (i_x_in_q),
        .i_y_in_q        (i_y_in_q),
        .i_intensity     (i_intensity),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_x_out_q       (o_x_out_q),
        .o_y_out_q       (o_y_out_q),
        .o_range_out_q   (o_range_out_q),
        .o_angle_out_q   (o_angle_out_q),
        .o_intensity_out (o_intensity_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_step(input int i);
        case (i)
            0:  return 32'h2000_0000;
            1:  return 32'h12E4_051D;
            2:  return 32'h09FB_385B;
            3:  return 32'h0511_11D4;
            4:  return 32'h028B_0D43;
            5:  return 32'h0145_D7E1;
            6:  return 32'h00A2_F61E;
            7:  return 32'h0051_7C55;
            8:  return 32'h0028_BE53;
            9:  return 32'h0014_5F2E;
            10: return 32'h000A_2F98;
            11: return 32'h0005_17CC;
            12: return 32'h0002_8BE6;
            13: return 32'h0001_45F3;
            14: return 32'h0000_A2F9;
            15: return 32'h0000_517C;
            16: return 32'h0000_28BE;
            17: return 32'h0000_145F;
            18: return 32'h0000_0A2F;
            19: return 32'h0000_0517;
            20: return 32'h0000_028B;
            21: return 32'h0000_0145;
            22: return 32'h0000_00A2;
            default: return 32'h0000_0051;
        endcase
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned cordic_inv_gain();
        longint unsigned p;
        longint unsigned k;
        p = 64'd1 << 60;
        for (int i = 0; i < pcc_pkg::N_STAGES; i++) p = p + (p >> (2 * i));
        k = root_floor(p);
        if (k == 0) k = 1;
        return (64'd1 << 60) / k;
    endfunction

    // drop gain and fraction bits, round half away from zero
    function automatic longint remove_gain(input longint v);
        longint unsigned m;
        longint unsigned t;
        longint unsigned r;
        m = (v < 0) ? -v : v;
        t = m * (inv_gain_q30 >> 15) + ((m * (inv_gain_q30 & 64'h7FFF)) >> 15);
        r = (t + (64'd1 << 22)) >> 23;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_point convert_point(input t_word w);
        t_point          p;
        longint          x;
        longint          y;
        longint          z;
        longint          th;
        longint          dx;
        longint          dy;
        longint unsigned mag;
        longint unsigned a;
        logic [31:0]     zu;
        bit              flip;
        p               = '0;
        p.kind          = w.cmd;
        p.intensity_out = w.inten;
        if (w.cmd == CMD_TO_XY) begin
            x    = clip(longint'(w.rng), 0, DIST_MAX);
            th   = longint'(w.ang) % pcc_pkg::TURN_Q;
            flip = 1'b0;
            // fold into [-90, 90] degrees, left half by negating the result
            if (th > pcc_pkg::QUARTER_Q) begin
                if (th <= 3 * pcc_pkg::QUARTER_Q) begin
                    th   = th - pcc_pkg::HALF_Q;
                    flip = 1'b1;
                end else begin
                    th = th - pcc_pkg::TURN_Q;
                end
            end
            mag = (th < 0) ? -th : th;
            mag = ((mag << 23) + 22) / 45;
            z   = (th < 0) ? -longint'(mag) : longint'(mag);
            x   = x * 256;
            y   = 0;
            for (int i = 0; i < pcc_pkg::N_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(atan_step(i));
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(atan_step(i));
                end
            end
            x = remove_gain(x);
            y = remove_gain(y);
            if (flip) begin
                x = -x;
                y = -y;
            end
            x       = clip(x, DIST_MIN, DIST_MAX);
            y       = clip(y, DIST_MIN, DIST_MAX);
            p.x_out = x[pcc_pkg::COORD_W-1:0];
            p.y_out = y[pcc_pkg::COORD_W-1:0];
        end else begin
            x = longint'(w.xin);
            y = longint'(w.yin);
            // the origin keeps range and angle at zero
            if (x != 0 || y != 0) begin
                zu = '0;
                if (x < 0) begin
                    x  = -x;
                    y  = -y;
                    zu = 32'h8000_0000;
                end
                x = x * 256;
                y = y * 256;
                for (int i = 0; i < pcc_pkg::N_STAGES; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y < 0) begin
                        x  = x - dx;
                        y  = y + dy;
                        zu = zu - atan_step(i);
                    end else begin
                        x  = x + dx;
                        y  = y - dy;
                        zu = zu + atan_step(i);
                    end
                end
                x           = clip(remove_gain(x), 0, DIST_MAX);
                p.range_out = x[pcc_pkg::RANGE_W-1:0];
                a           = longint'(zu);
                a           = (a * pcc_pkg::TURN_Q + 64'h8000_0000) >> 32;
                if (a >= pcc_pkg::TURN_Q) a = 0;
                p.angle_out = a[pcc_pkg::ANGLE_W-1:0];
            end
        end
        return p;
    endfunction

    function automatic logic signed [pcc_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return -19'sd262144;
            1:       return 19'sd262143;
            2:       return pcc_pkg::COORD_W'($urandom_range(0, 40) - 20);
            default: return pcc_pkg::COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_word random_word();
        t_word w;
        w.cmd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       w.rng = '0;
            1:       w.rng = '1;
            2:       w.rng = pcc_pkg::RANGE_W'($urandom_range(0, 255));
            default: w.rng = pcc_pkg::RANGE_W'($urandom);
        endcase
        // quadrant edges, out-of-turn angles, then anything in the turn
        case ($urandom_range(0, 7))
            0:       w.ang = pcc_pkg::ANGLE_W'($urandom_range(0, 4) * pcc_pkg::QUARTER_Q
                                               + $urandom_range(0, 2) - 1);
            1:       w.ang = pcc_pkg::ANGLE_W'($urandom_range(pcc_pkg::TURN_Q, 32767));
            default: w.ang = pcc_pkg::ANGLE_W'($urandom_range(0, pcc_pkg::TURN_Q - 1));
        endcase
        w.xin   = rand_coord();
        w.yin   = rand_coord();
        w.inten = pcc_pkg::INTEN_W'($urandom);
        return w;
    endfunction

    task automatic put_word(input t_word w, input logic pin, input t_point pv);
        @(negedge i_clk);
        start       <= 1'b1;
        i_command   <= w.cmd;
        i_range_q   <= w.rng;
        i_angle_q   <= w.ang;
        i_x_in_q    <= w.xin;
        i_y_in_q    <= w.yin;
        i_intensity <= w.inten;
        pin_on      <= pin;
        pin_val     <= pv;
        do @(posedge i_clk); while (busy);
    endtask

    // no word offered, payload scrambled
    task automatic idle_cycle();
        @(negedge i_clk);
        start       <= 1'b0;
        i_command   <= 1'($urandom_range(0, 1));
        i_range_q   <= pcc_pkg::RANGE_W'($urandom);
        i_angle_q   <= pcc_pkg::ANGLE_W'($urandom);
        i_x_in_q    <= pcc_pkg::COORD_W'($urandom);
        i_y_in_q    <= pcc_pkg::COORD_W'($urandom);
        i_intensity <= pcc_pkg::INTEN_W'($urandom);
        pin_on      <= 1'b0;
    endtask

    task automatic drain_points();
        idle_cycle();
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_point want;
        t_word  w;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_points.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with nothing pending, expected none, got kind %0d",
                             $time, o_kind);
                end else begin
                    want = pending_points.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("x_out_q", want.x_out, o_x_out_q);
                    check_field("y_out_q", want.y_out, o_y_out_q);
                    check_field("range_out_q", want.range_out, o_range_out_q);
                    check_field("angle_out_q", want.angle_out, o_angle_out_q);
                    check_field("intensity_out", want.intensity_out, o_intensity_out);
                end
            end
            if (start && !busy) begin
                w    = '{i_command, i_range_q, i_angle_q, i_x_in_q, i_y_in_q, i_intensity};
                want = pin_on ? pin_val : convert_point(w);
                pending_points = {pending_points, want};
            end
        end
    end

    initial begin : stimulus
        int pct;
        inv_gain_q30   = cordic_inv_gain();
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = CMD_TO_XY;
        i_range_q      = '0;
        i_angle_q      = '0;
        i_x_in_q       = '0;
        i_y_in_q       = '0;
        i_intensity    = '0;
        pin_on         = 1'b0;
        pin_val        = '0;

        // origin and zero range give all-zero results
        dir_rows[0]  = '{'{CMD_TO_POLAR, 18'd5, 15'd9, 19'sd0, 19'sd0, 16'hFFFF}, 1'b1,
                         '{CMD_TO_POLAR, 19'sd0, 19'sd0, 18'd0, 15'd0, 16'hFFFF}};
        dir_rows[1]  = '{'{CMD_TO_XY, 18'd0, 15'd0, -19'sd1, 19'sd262143, 16'h0000}, 1'b1,
                         '{CMD_TO_XY, 19'sd0, 19'sd0, 18'd0, 15'd0, 16'h0000}};
        dir_rows[2]  = '{'{CMD_TO_XY, 18'd0, 15'd32767, 19'sd7, -19'sd7, 16'h1234}, 1'b1,
                         '{CMD_TO_XY, 19'sd0, 19'sd0, 18'd0, 15'd0, 16'h1234}};
        // full range on the axes and at 45 degrees, the turn boundary and out-of-turn angles, then smaller ranges
        dir_rows[3]  = '{'{CMD_TO_XY, 18'h3FFFF, 15'd0, 19'sd0, 19'sd0, 16'h0001}, 1'b0, '0};
        dir_rows[4]  = '{'{CMD_TO_XY, 18'h3FFFF, 15'd5760, 19'sd0, 19'sd0, 16'h8000}, 1'b0, '0};
        dir_rows[5]  = '{'{CMD_TO_XY, 18'h3FFFF, 15'd11520, 19'sd0, 19'sd0, 16'h00FF}, 1'b0, '0};
        dir_rows[6]  = '{'{CMD_TO_XY, 18'h3FFFF, 15'd17280, 19'sd0, 19'sd0, 16'hFF00}, 1'b0, '0};
        dir_rows[7]  = '{'{CMD_TO_XY, 18'h3FFFF, 15'd23039, 19'sd0, 19'sd0, 16'h5555}, 1'b0, '0};
        dir_rows[8]  = '{'{CMD_TO_XY, 18'h3FFFF, 15'd23040, 19'sd0, 19'sd0, 16'hAAAA}, 1'b0, '0};
        dir_rows[9]  = '{'{CMD_TO_XY, 18'h3FFFF, 15'd32767, 19'sd0, 19'sd0, 16'h0F0F}, 1'b0, '0};
        dir_rows[10] = '{'{CMD_TO_XY, 18'h3FFFF, 15'd2880, 19'sd0, 19'sd0, 16'hF0F0}, 1'b0, '0};
        dir_rows[11] = '{'{CMD_TO_XY, 18'h2AAAA, 15'd17281, 19'sd0, 19'sd0, 16'h0002}, 1'b0, '0};
        dir_rows[12] = '{'{CMD_TO_XY, 18'h15555, 15'd5761, 19'sd0, 19'sd0, 16'h0004}, 1'b0, '0};
        dir_rows[13] = '{'{CMD_TO_XY, 18'd1, 15'd1, 19'sd0, 19'sd0, 16'h0008}, 1'b0, '0};
        dir_rows[14] = '{'{CMD_TO_XY, 18'd4, 15'd23039, 19'sd0, 19'sd0, 16'h0010}, 1'b0, '0};
        // coordinate extremes, saturating range, angles near the wrap
        dir_rows[15] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, 19'sd262143, 19'sd0, 16'h0020}, 1'b0, '0};
        dir_rows[16] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, -19'sd262144, 19'sd0, 16'h0040}, 1'b0, '0};
        dir_rows[17] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, 19'sd0, 19'sd262143, 16'h0080}, 1'b0, '0};
        dir_rows[18] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, 19'sd0, -19'sd262144, 16'h0100}, 1'b0, '0};
        dir_rows[19] = '{'{CMD_TO_POLAR, 18'h3FFFF, 15'h7FFF, -19'sd262144, -19'sd262144,
                           16'h0200}, 1'b0, '0};
        dir_rows[20] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, 19'sd262143, 19'sd262143, 16'h0400},
                         1'b0, '0};
        dir_rows[21] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, -19'sd1, 19'sd0, 16'h0800}, 1'b0, '0};
        dir_rows[22] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, 19'sd1, -19'sd1, 16'h1000}, 1'b0, '0};
        dir_rows[23] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, -19'sd262144, -19'sd1, 16'h2000},
                         1'b0, '0};
        dir_rows[24] = '{'{CMD_TO_POLAR, 18'd0, 15'd0, 19'sd5, -19'sd3, 16'h4000}, 1'b0, '0};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) put_word(dir_rows[r].w, dir_rows[r].pinned,
                                                    dir_rows[r].want);
        drain_points();

        // back to back, sparse sender, moderate gaps, back to back again
        for (int ph = 0; ph < 4; ph++) begin
            pct = (ph == 1) ? 62 : ((ph == 2) ? 28 : 0);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                while ($urandom_range(0, 99) < pct) idle_cycle();
                put_word(random_word(), 1'b0, '0);
            end
            drain_points();
        end

        repeat (3 + pcc_pkg::N_STAGES + 10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
